### sv/air_pkg.sv
// shared types and constants for the aabb impulse resolution pipeline
package air_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;

	typedef enum logic [1:0] {
		OUTCOME_IMPULSE   = 2'd0,
		OUTCOME_SEPARATE  = 2'd1,
		OUTCOME_ZERO_MASS = 2'd2
	} outcome_t;

	// per-pair sideband that rides alongside the divider
	typedef struct packed {
		logic [31:0] im_first;
		logic [31:0] im_second;
		logic        along_y;
		logic        neg;
		logic        separating;
		logic        zero_mass;
	} side_t;

endpackage

### sv/air_div.sv
// pipelined restoring divider, one quotient bit per stage
module air_div #(
	parameter int FRAC_BITS = air_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [FRAC_BITS+32:0]   num,
	input  logic [32:0]             den,
	input  air_pkg::side_t          side_in,
	output logic                    out_vld,
	output logic [FRAC_BITS+32:0]   quo,
	output air_pkg::side_t          side_out
);

	localparam int NW    = FRAC_BITS + 33;
	localparam int REM_W = 33;

	logic                 vld_s  [1:NW];
	logic [REM_W-1:0]     rem_s  [1:NW];
	logic [NW-1:0]        num_s  [1:NW];
	logic [NW-1:0]        quo_s  [1:NW];
	logic [REM_W-1:0]     den_s  [1:NW];
	air_pkg::side_t       side_s [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic             vld_in;
		logic [REM_W-1:0] rem_in;
		logic [NW-1:0]    num_in;
		logic [NW-1:0]    quo_in;
		logic [REM_W-1:0] den_in;
		air_pkg::side_t   side_k;
		logic [REM_W:0]   trial;
		logic             fits;
		logic [REM_W:0]   diff;
		logic [REM_W-1:0] rem_next;

		if (k == 0) begin : g_head
			assign vld_in = in_vld;
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign side_k = side_in;
		end else begin : g_body
			assign vld_in = vld_s[k];
			assign rem_in = rem_s[k];
			assign num_in = num_s[k];
			assign quo_in = quo_s[k];
			assign den_in = den_s[k];
			assign side_k = side_s[k];
		end

		assign trial    = {rem_in, num_in[NW-1]};
		assign fits     = trial >= {1'b0, den_in};
		assign diff     = trial - {1'b0, den_in};
		assign rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_next;
				num_s[k+1]  <= {num_in[NW-2:0], 1'b0};
				quo_s[k+1]  <= {quo_in[NW-2:0], fits};
				den_s[k+1]  <= den_in;
				side_s[k+1] <= side_k;
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign quo      = quo_s[NW];
	assign side_out = side_s[NW];

endmodule

### sv/aabb_impulse_resolution_core.sv
// top level: aabb collision impulse pipeline, one pair per cycle while the output drains
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | 256-bit tdata, pair geometry
//  m_axis    | out       | m_axis_tvalid/tready   | 128-bit tdata, 2-bit tuser
//
// the pipeline has two setup stages, one divider stage per quotient bit
// (FRAC_BITS + 33, with FRAC_BITS = 16 at Q16.16), two multiply stages and
// the output register. one pair is taken every cycle while the output is drained.
// reset clears only the valid bits. when a result waits and m_axis_tready is
// low, every stage holds and s_axis_tready drops.
module aabb_impulse_resolution_core #(
	parameter int FRAC_BITS = air_pkg::FRAC_BITS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, half_extent_sum_x,
	// half_extent_sum_y, first inverse mass, second inverse mass, zero pad
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// dv_first_x, dv_first_y, dv_second_x, dv_second_y
	output logic [127:0] m_axis_tdata,
	// outcome
	output logic [1:0]   m_axis_tuser
);

	localparam int NW = FRAC_BITS + 33;
	localparam int JH = NW - 32;
	localparam int PW = NW + 32;

	function automatic logic [31:0] sat_sign(input logic neg, input logic big,
						 input logic [30:0] mag);
		logic [31:0] ext;
		ext = {1'b0, mag};
		if (neg) begin
			sat_sign = big ? 32'h8000_0000 : 32'd0 - ext;
		end else begin
			sat_sign = big ? 32'h7fff_ffff : ext;
		end
	endfunction

	logic adv;
	assign adv           = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = adv;

	// field unpack
	logic [31:0] px, py, vx, vy, im1, im2;
	logic [30:0] hx, hy;
	assign px  = s_axis_tdata[31:0];
	assign py  = s_axis_tdata[63:32];
	assign vx  = s_axis_tdata[95:64];
	assign vy  = s_axis_tdata[127:96];
	assign hx  = s_axis_tdata[158:128];
	assign hy  = s_axis_tdata[189:159];
	assign im1 = s_axis_tdata[221:190];
	assign im2 = s_axis_tdata[253:222];

	// stage 1: overlaps and mass sum
	logic [32:0] px_mag, py_mag;
	assign px_mag = px[31] ? 33'd0 - {1'b1, px} : {1'b0, px};
	assign py_mag = py[31] ? 33'd0 - {1'b1, py} : {1'b0, py};

	logic        vld_s1;
	logic [32:0] ox_s1, oy_s1, sum_s1;
	logic        pxn_s1, pyn_s1;
	logic [31:0] vx_s1, vy_s1, im1_s1, im2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s1  <= {2'b00, hx} - px_mag;
			oy_s1  <= {2'b00, hy} - py_mag;
			sum_s1 <= {1'b0, im1} + {1'b0, im2};
			pxn_s1 <= px[31];
			pyn_s1 <= py[31];
			vx_s1  <= vx;
			vy_s1  <= vy;
			im1_s1 <= im1;
			im2_s1 <= im2;
		end
	end

	// stage 2: pick the normal, velocity along it
	logic        along_y, neg;
	logic [31:0] vsel;
	logic [32:0] van, van_neg;
	assign along_y = $signed(ox_s1) > $signed(oy_s1);
	assign neg     = along_y ? pyn_s1 : pxn_s1;
	assign vsel    = along_y ? vy_s1 : vx_s1;
	assign van     = neg ? 33'd0 - {vsel[31], vsel} : {vsel[31], vsel};
	assign van_neg = 33'd0 - van;

	logic           vld_s2;
	logic [31:0]    a_s2;
	logic [32:0]    sum_s2;
	air_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2               <= van_neg[31:0];
			sum_s2             <= sum_s1;
			side_s2.im_first   <= im1_s1;
			side_s2.im_second  <= im2_s1;
			side_s2.along_y    <= along_y;
			side_s2.neg        <= neg;
			side_s2.separating <= ~van[32] & (van != 33'd0);
			side_s2.zero_mass  <= sum_s1 == 33'd0;
		end
	end

	// impulse magnitude j = (2 * |v| << FRAC_BITS) / mass sum
	logic           div_vld;
	logic [NW-1:0]  j;
	air_pkg::side_t div_side;

	air_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s2),
		.num     ({a_s2, {(FRAC_BITS + 1){1'b0}}}),
		.den     (sum_s2),
		.side_in (side_s2),
		.out_vld (div_vld),
		.quo     (j),
		.side_out(div_side)
	);

	// stage 3: partial products of j times each inverse mass
	logic           vld_s3;
	logic [63:0]    pl1_s3, pl2_s3;
	logic [JH+31:0] ph1_s3, ph2_s3;
	air_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl1_s3  <= j[31:0] * div_side.im_first;
			pl2_s3  <= j[31:0] * div_side.im_second;
			ph1_s3  <= j[NW-1:32] * div_side.im_first;
			ph2_s3  <= j[NW-1:32] * div_side.im_second;
			side_s3 <= div_side;
		end
	end

	// stage 4: full products, shifted magnitude and overflow flag
	logic [PW-1:0] prod1, prod2;
	assign prod1 = {ph1_s3, 32'd0} + {{(PW - 64){1'b0}}, pl1_s3};
	assign prod2 = {ph2_s3, 32'd0} + {{(PW - 64){1'b0}}, pl2_s3};

	logic           vld_s4;
	logic           big1_s4, big2_s4;
	logic [30:0]    mag1_s4, mag2_s4;
	air_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	// magnitude reaches 2^31 or more once any bit above FRAC_BITS + 30 is set
	always_ff @(posedge clk) begin
		if (adv) begin
			big1_s4 <= |prod1[PW-1:FRAC_BITS+31];
			big2_s4 <= |prod2[PW-1:FRAC_BITS+31];
			mag1_s4 <= prod1[FRAC_BITS+30:FRAC_BITS];
			mag2_s4 <= prod2[FRAC_BITS+30:FRAC_BITS];
			side_s4 <= side_s3;
		end
	end

	// output register: sign, saturate, place on the normal axis
	logic [31:0]       d1, d2;
	logic [127:0]      data_d;
	air_pkg::outcome_t outcome_d;

	assign d1 = sat_sign(~side_s4.neg, big1_s4, mag1_s4);
	assign d2 = sat_sign(side_s4.neg, big2_s4, mag2_s4);

	always_comb begin
		data_d    = '0;
		outcome_d = air_pkg::OUTCOME_IMPULSE;
		if (side_s4.separating) begin
			outcome_d = air_pkg::OUTCOME_SEPARATE;
		end else if (side_s4.zero_mass) begin
			outcome_d = air_pkg::OUTCOME_ZERO_MASS;
		end else if (side_s4.along_y) begin
			data_d[63:32]  = d1;
			data_d[127:96] = d2;
		end else begin
			data_d[31:0]   = d1;
			data_d[95:64]  = d2;
		end
	end

	logic              out_vld_q;
	logic [127:0]      out_data_q;
	air_pkg::outcome_t out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= data_d;
			out_user_q <= outcome_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

### sv/air_chk.sv
// port-level checker for the aabb impulse resolution core, bound to the top level
module air_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	// input side only backs up while a result is held
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a held result");

	// separating and zero mass results carry no velocity change
	a_no_impulse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != air_pkg::OUTCOME_IMPULSE)
		|-> m_axis_tdata == 128'd0)
		else $error("nonzero velocity change without an impulse");

	// an impulse acts on one axis only
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == air_pkg::OUTCOME_IMPULSE)
		|-> ((m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[95:64] == 32'd0) ||
		     (m_axis_tdata[63:32] == 32'd0 && m_axis_tdata[127:96] == 32'd0)))
		else $error("impulse on both axes");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready)
		|=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("held result changed");

endmodule

bind aabb_impulse_resolution_core air_chk u_air_chk (.*);
